@@ rtl/segmented_node_to_element_map_core_defines.svh @@
// ----------------------------------------------------------------------------
// segmented node-to-element map: assertion macros
// wrappers around concurrent assertions, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_NODE_TO_ELEMENT_MAP_CORE_DEFINES_SVH
`define SEGMENTED_NODE_TO_ELEMENT_MAP_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define SNMAP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define SNMAP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SNMAP_ASSERT(label, clk, rst_n, prop, msg)
`define SNMAP_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

@@ rtl/snmap_pkg.sv @@
// ----------------------------------------------------------------------------
// snmap_pkg
// shared types and constants of the segmented node-to-element map
// ----------------------------------------------------------------------------
package snmap_pkg;

	localparam int MAX_RODS = 16;
	localparam int ROD_W    = $clog2(MAX_RODS);
	localparam int RCNT_W   = ROD_W + 1;
	localparam int NODE_W   = 32;
	localparam int CNT_W    = 16;
	localparam int GLOB_W   = 20;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// query token walking down the rod chain
	typedef struct packed {
		logic              valid;
		logic [NODE_W-1:0] node;
		logic [GLOB_W-1:0] base;
		logic              found;
		logic [ROD_W-1:0]  sel;
		logic [NODE_W-1:0] sel_start;
		logic [CNT_W-1:0]  sel_cnt;
		logic [GLOB_W-1:0] sel_base;
	} tok_t;

endpackage

@@ rtl/snmap_cell.sv @@
// ----------------------------------------------------------------------------
// snmap_cell
// one rod slot: holds start node and element count, checks a passing token
// ----------------------------------------------------------------------------
module snmap_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [snmap_pkg::ROD_W-1:0]   cell_idx,
	input  logic [snmap_pkg::RCNT_W-1:0]  rod_n,
	input  logic                          wr_en,
	input  logic [snmap_pkg::NODE_W-1:0]  wr_start,
	input  logic [snmap_pkg::CNT_W-1:0]   wr_cnt,
	input  snmap_pkg::tok_t               tok_in,
	input  logic [snmap_pkg::NODE_W-1:0]  next_start,
	output logic [snmap_pkg::NODE_W-1:0]  start_out,
	output snmap_pkg::tok_t               tok_out
);
	import snmap_pkg::*;

	logic [NODE_W-1:0] start_q;
	logic [CNT_W-1:0]  cnt_q;
	tok_t              tok_q;
	tok_t              tok_nxt;
	logic              active;
	logic              last;
	logic              hit;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_q <= wr_start;
			cnt_q   <= wr_cnt;
		end
	end

	always_comb begin
		active = {1'b0, cell_idx} < rod_n;
		last   = ({1'b0, cell_idx} + RCNT_W'(1)) == rod_n;
		// last rod in use is open above
		hit    = active && !tok_in.found && (tok_in.node >= start_q) &&
			(last || (tok_in.node < next_start));
		tok_nxt       = tok_in;
		tok_nxt.found = tok_in.found | hit;
		tok_nxt.base  = tok_in.base + GLOB_W'(cnt_q);
		// first cell loads rod 0 as the fallback choice
		if (hit || (cell_idx == '0)) begin
			tok_nxt.sel       = cell_idx;
			tok_nxt.sel_start = start_q;
			tok_nxt.sel_cnt   = cnt_q;
			tok_nxt.sel_base  = tok_in.base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign start_out = start_q;
	assign tok_out   = tok_q;

endmodule

@@ rtl/segmented_node_to_element_map_core.sv @@
// ----------------------------------------------------------------------------
// segmented_node_to_element_map_core
// rod table with node-to-element lookup through a chain of rod cells
// ----------------------------------------------------------------------------
// usage
//   cfg_valid/cfg_data set the number of rods in use (saturates at 16); write
//   it only while the block is idle. cfg_ready is always high.
//   s_* beats carry one request: s_tuser selects a table write or a query.
//   a write loads one rod slot and returns an ack beat with status ok.
//   a query walks the 16 rod cells, one cell per cycle, and returns the rod,
//   the local element and the global element, or an empty/range status.
//   m_* beats carry one result per request, in request order.
// request flow
//   one request in flight at a time. a query result passes the cell chain,
//   the result register and the output register; a write or an empty-table
//   query passes the result and output registers only. the next beat is
//   accepted once the result moves into the output register.
// reset and stall
//   reset clears the rod count, the chain and both result registers; table
//   contents are not cleared. while m_tready is low the result waits in the
//   output register and one more finished result waits behind it.
// ----------------------------------------------------------------------------
`include "segmented_node_to_element_map_core_defines.svh"

module segmented_node_to_element_map_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: rod count
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	// requests
	input  logic        s_tvalid,
	output logic        s_tready,
	// node_index[31:0], rod_slot[35:32], start_node[67:36], elem_count[83:68]
	input  logic [87:0] s_tdata,
	// req_type[0]
	input  logic [0:0]  s_tuser,
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	// rod_sel[3:0], local_element[19:4], global_element[39:20]
	output logic [39:0] m_tdata,
	// status[1:0]
	output logic [1:0]  m_tuser
);
	import snmap_pkg::*;

	logic [RCNT_W-1:0] rod_count_q;
	logic [RCNT_W-1:0] rod_n;
	logic              busy_q;
	logic              acc;
	logic              is_query;
	logic              launch;
	logic              move;

	logic [NODE_W-1:0] in_node;
	logic [ROD_W-1:0]  in_slot;
	logic [NODE_W-1:0] in_start;
	logic [CNT_W-1:0]  in_cnt;

	tok_t              launch_tok;
	tok_t              tok_out   [MAX_RODS];
	logic [NODE_W-1:0] start_vec [MAX_RODS];
	logic [MAX_RODS-1:0] tok_vld;
	tok_t              tail;

	logic              res_valid_q;
	status_t           res_status_q;
	logic [ROD_W-1:0]  res_sel_q;
	logic [CNT_W-1:0]  res_ln_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic [GLOB_W-1:0] res_base_q;

	logic [NODE_W-1:0] diff;
	logic              past_rod;

	logic [CNT_W-1:0]  loc_elem;
	logic [GLOB_W-1:0] glob_elem;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [ROD_W-1:0]  out_rod_q;
	logic [CNT_W-1:0]  out_loc_q;
	logic [GLOB_W-1:0] out_glob_q;

	assign in_node  = s_tdata[31:0];
	assign in_slot  = s_tdata[35:32];
	assign in_start = s_tdata[67:36];
	assign in_cnt   = s_tdata[83:68];

	assign cfg_ready = 1'b1;
	assign rod_n     = (rod_count_q > RCNT_W'(MAX_RODS)) ? RCNT_W'(MAX_RODS) : rod_count_q;

	assign s_tready = !busy_q;
	assign acc      = s_tvalid && s_tready;
	assign is_query = s_tuser[0] == REQ_QUERY;
	assign launch   = acc && is_query && (rod_n != '0);
	assign move     = res_valid_q && (!out_valid_q || m_tready);

	always_comb begin
		launch_tok       = '0;
		launch_tok.valid = launch;
		launch_tok.node  = in_node;
	end

	for (genvar k = 0; k < MAX_RODS; k++) begin : g_cell
		tok_t              c_in;
		logic [NODE_W-1:0] c_next;

		if (k == 0) begin : g_head
			assign c_in = launch_tok;
		end else begin : g_body
			assign c_in = tok_out[k-1];
		end

		if (k == MAX_RODS - 1) begin : g_end
			assign c_next = '0;
		end else begin : g_mid
			assign c_next = start_vec[k+1];
		end

		snmap_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_idx   (ROD_W'(k)),
			.rod_n      (rod_n),
			.wr_en      (acc && (s_tuser[0] == REQ_WRITE) && (in_slot == ROD_W'(k))),
			.wr_start   (in_start),
			.wr_cnt     (in_cnt),
			.tok_in     (c_in),
			.next_start (c_next),
			.start_out  (start_vec[k]),
			.tok_out    (tok_out[k])
		);

		assign tok_vld[k] = tok_out[k].valid;
	end

	assign tail = tok_out[MAX_RODS-1];

	// range check of the chosen rod
	always_comb begin
		diff     = tail.node - tail.sel_start;
		past_rod = (tail.node < tail.sel_start) || (diff > NODE_W'(tail.sel_cnt));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rod_count_q <= '0;
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				rod_count_q <= cfg_data;
			end
			if (acc) begin
				busy_q <= 1'b1;
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if ((acc && !launch) || tail.valid) begin
				res_valid_q <= 1'b1;
			end else if (move) begin
				res_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !launch) begin
			res_status_q <= is_query ? ST_EMPTY : ST_OK;
			res_sel_q    <= '0;
			res_ln_q     <= '0;
			res_cnt_q    <= '0;
			res_base_q   <= '0;
		end else if (tail.valid) begin
			res_status_q <= past_rod ? ST_RANGE : ST_OK;
			res_sel_q    <= tail.sel;
			res_ln_q     <= diff[CNT_W-1:0];
			res_cnt_q    <= tail.sel_cnt;
			res_base_q   <= tail.sel_base;
		end
	end

	// first node -> 0, inner node k -> k-1, last node -> count-1
	always_comb begin
		if (res_status_q != ST_OK || res_ln_q == '0) begin
			loc_elem = '0;
		end else if (res_ln_q < res_cnt_q) begin
			loc_elem = res_ln_q - CNT_W'(1);
		end else begin
			loc_elem = res_cnt_q - CNT_W'(1);
		end
		glob_elem = (res_status_q == ST_OK) ? (res_base_q + GLOB_W'(loc_elem)) : '0;
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_status_q <= res_status_q;
			out_rod_q    <= (res_status_q == ST_EMPTY) ? '0 : res_sel_q;
			out_loc_q    <= loc_elem;
			out_glob_q   <= glob_elem;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {out_glob_q, out_loc_q, out_rod_q};

	logic [MAX_RODS:0] inflight_vec;
	assign inflight_vec = {res_valid_q, tok_vld};

	`SNMAP_ASSERT(a_one_inflight, clk, arst_n, $onehot0(inflight_vec),
		"more than one request in flight")
	`SNMAP_ASSERT(a_chain_busy, clk, arst_n, (tok_vld != '0) |-> busy_q,
		"token in chain while not busy")
	`SNMAP_ASSERT(a_res_busy, clk, arst_n, res_valid_q |-> busy_q,
		"pending result while not busy")
	`SNMAP_ASSERT(a_launch, clk, arst_n, launch |=> tok_vld[0],
		"accepted query did not enter the chain")
	`SNMAP_ASSERT_NEVER(a_bad_status, clk, arst_n, out_valid_q && (m_tuser == 2'd3),
		"undefined status on output")

endmodule
